// ===== rtl/mdb_pkg.sv =====
`default_nettype none
package mdb_pkg;

	typedef struct packed {
		logic       op;
		logic [8:0] rx_word;
	} in_item_t;

	typedef struct packed {
		logic [8:0] tx_word;
		logic       last;
	} out_item_t;

	typedef enum logic [2:0] {
		CMD_RESET    = 3'd0,
		CMD_SETUP    = 3'd1,
		CMD_SECURITY = 3'd2,
		CMD_POLL     = 3'd3,
		CMD_BILLTYPE = 3'd4,
		CMD_ESCROW   = 3'd5,
		CMD_STACKER  = 3'd6,
		CMD_EXPAND   = 3'd7
	} cmd_t;

	typedef enum logic [1:0] {
		VMODE_INACTIVE = 2'd0,
		VMODE_DISABLED = 2'd1,
		VMODE_ENABLED  = 2'd2
	} vmode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DRAIN,
		ST_RING,
		ST_EMIT,
		ST_SUM
	} state_t;

	localparam logic [2:0] REG_ADDR     = 3'd0;
	localparam logic [2:0] REG_CAPACITY = 3'd1;
	localparam logic [2:0] REG_CURRENCY = 3'd2;
	localparam logic [2:0] REG_SCALE    = 3'd3;
	localparam logic [2:0] REG_DECIMALS = 3'd4;
	localparam logic [2:0] REG_VERSION  = 3'd5;

	localparam logic [7:0] EV_STACKED    = 8'h80;
	localparam logic [7:0] ST_JUST_RESET = 8'h06;

	function automatic logic [2:0] data_words(input logic [2:0] c);
		case (c)
			CMD_SECURITY: data_words = 3'd2;
			CMD_BILLTYPE: data_words = 3'd4;
			CMD_ESCROW:   data_words = 3'd1;
			CMD_EXPAND:   data_words = 3'd1;
			default:      data_words = 3'd0;
		endcase
	endfunction

	function automatic logic [7:0] credit(input logic [3:0] i);
		case (i)
			4'd0: credit = 8'd1;
			4'd1: credit = 8'd2;
			4'd2: credit = 8'd5;
			4'd3: credit = 8'd10;
			4'd4: credit = 8'd20;
			4'd5: credit = 8'd50;
			4'd6: credit = 8'd100;
			default: credit = 8'd0;
		endcase
	endfunction

endpackage
`default_nettype wire

// ===== rtl/mdb_ring.sv =====
`default_nettype none
module mdb_ring #(
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [7:0]    wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [7:0]    rdata
);
	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== rtl/mdb_bill_validator_slave_top.sv =====
`default_nettype none
// MDB Level 1 bill validator, slave side.
// Input channel (in_valid/in_ready/in_data): each item is either a received
// 9-bit bus word (op=0) or one bill-insert event (op=1).
// Output channel (out_valid/out_ready/out_data): reply words, one per item,
// the last one is the checksum with bit 8 set and last=1.
// Configuration: cfg_we/cfg_index/cfg_data write the six setup registers;
// write only while the block is idle.
// Flow: a word that causes no reply is absorbed while the block stays idle.
// After the item that completes a frame, the n reply words and the checksum
// leave at one per cycle while out_ready is high. POLL first drains pending
// inserts at one per cycle, then reads queued events from the ring memory
// one at a time (after a RESET it replies with the just-reset status instead).
// A single 8-bit adder accumulates the reply checksum word by word.
// in_ready is low from frame completion until the checksum item is taken.
// When out_ready is low the current word holds (idx_q does not advance) and
// the sequencer waits.
// Reset clears all control state, masks, counters and ring pointers; the
// ring memory and frame data are not cleared (read only after written).
module mdb_bill_validator_slave_top #(
	parameter int RING_DEPTH    = 16,
	parameter int PENDING_LIMIT = 255
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire mdb_pkg::in_item_t  in_data,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output mdb_pkg::out_item_t      out_data,
	input  wire logic               cfg_we,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [15:0]        cfg_data
);
	localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int PW = $clog2(PENDING_LIMIT + 1);
	localparam logic [AW-1:0] RING_LAST = AW'(RING_DEPTH - 1);
	localparam logic [PW-1:0] PEND_MAX  = PW'(PENDING_LIMIT);

	// configuration registers
	logic [4:0]  addr_q;
	logic [14:0] cap_q;
	logic [15:0] cur_q, scale_q, version_q;
	logic [7:0]  dec_q;

	// frame state
	logic [2:0]  cmd_q;
	logic [2:0]  left_q;
	logic [7:0]  fsum_q;
	logic [7:0]  fdata_q [4];
	mdb_pkg::vmode_t vmode_q;
	logic        jr_q;
	logic [15:0] bill_mask_q, esc_mask_q;
	logic [14:0] stacked_q;
	logic [PW-1:0] pend_q;
	logic [AW-1:0] head_q, tail_q;

	// sequencer
	mdb_pkg::state_t st_q, st_d;
	logic [4:0]  idx_q;    // word index within reply
	logic [4:0]  n_q;      // reply length (data words)
	logic [7:0]  rsum_q;   // running reply checksum
	logic [7:0]  pollw_q [16];
	logic        rd_pend_q;

	function automatic logic [AW-1:0] inc(input logic [AW-1:0] a);
		inc = (a == RING_LAST) ? '0 : a + 1'b1;
	endfunction

	logic [7:0] ring_rdata;
	logic       ring_we;
	logic [AW-1:0] head_nx;
	assign head_nx = inc(head_q);

	mdb_ring #(.DEPTH(RING_DEPTH)) u_ring (
		.clk  (clk),
		.we   (ring_we),
		.waddr(head_q),
		.wdata(mdb_pkg::EV_STACKED),
		.raddr(tail_q),
		.rdata(ring_rdata)
	);

	logic in_fire, out_fire;
	assign in_fire  = in_valid && in_ready;
	assign out_fire = out_valid && out_ready;
	assign in_ready = (st_q == mdb_pkg::ST_IDLE);

	// reply word by index
	logic [7:0] word;
	always_comb begin
		word = 8'h00;
		case (cmd_q)
			mdb_pkg::CMD_SETUP: begin
				case (idx_q)
					5'd0: word = 8'h01;
					5'd1: word = cur_q[15:8];
					5'd2: word = cur_q[7:0];
					5'd3: word = scale_q[15:8];
					5'd4: word = scale_q[7:0];
					5'd5: word = dec_q;
					5'd6: word = {1'b0, cap_q[14:8]};
					5'd7: word = cap_q[7:0];
					5'd8, 5'd9, 5'd10: word = 8'h00;
					default: word = mdb_pkg::credit(4'(idx_q - 5'd11));
				endcase
			end
			mdb_pkg::CMD_STACKER: begin
				if (idx_q == 5'd0) begin
					word = {(stacked_q >= cap_q), stacked_q[14:8]};
				end else begin
					word = stacked_q[7:0];
				end
			end
			mdb_pkg::CMD_EXPAND: begin
				case (idx_q)
					5'd0: word = 8'h4D;
					5'd1: word = 8'h44;
					5'd2: word = 8'h42;
					5'd27: word = version_q[15:8];
					5'd28: word = version_q[7:0];
					default: word = 8'h20;
				endcase
			end
			mdb_pkg::CMD_POLL: word = pollw_q[idx_q[3:0]];
			default: word = 8'h00;
		endcase
	end

	// input decode
	logic [7:0] lo;
	logic       hdr_ok, sum_ok, exp_nak;
	logic [2:0] dw;
	assign lo = in_data.rx_word[7:0];
	assign dw = mdb_pkg::data_words(cmd_q);
	assign hdr_ok = in_data.rx_word[8] && lo != 8'h00 && lo != 8'hAA && lo != 8'hFF
		&& in_data.rx_word[7:3] == addr_q;
	assign sum_ok = in_data.rx_word == {1'b0, fsum_q};
	assign exp_nak = cmd_q == mdb_pkg::CMD_EXPAND && lo != 8'h00;

	logic enabled;
	assign enabled = vmode_q == mdb_pkg::VMODE_ENABLED && bill_mask_q[0];
	assign ring_we = st_q == mdb_pkg::ST_DRAIN && pend_q != '0 && enabled
		&& head_nx != tail_q;

	always_comb begin
		st_d = st_q;
		case (st_q)
			mdb_pkg::ST_IDLE: begin
				if (in_fire && !in_data.op && left_q != 3'd0) begin
					if (left_q > 3'd1) begin
						if (exp_nak) st_d = mdb_pkg::ST_SUM;
					end else if (sum_ok) begin
						case (cmd_q)
							mdb_pkg::CMD_POLL:  st_d = mdb_pkg::ST_DRAIN;
							mdb_pkg::CMD_SETUP, mdb_pkg::CMD_STACKER,
							mdb_pkg::CMD_EXPAND: st_d = mdb_pkg::ST_EMIT;
							default:            st_d = mdb_pkg::ST_SUM;
						endcase
					end
				end
			end
			mdb_pkg::ST_DRAIN: begin
				if (pend_q == '0) begin
					st_d = jr_q ? mdb_pkg::ST_EMIT : mdb_pkg::ST_RING;
				end
			end
			mdb_pkg::ST_RING: begin
				if (!rd_pend_q && (head_q == tail_q || n_q == 5'd16)) begin
					st_d = (n_q == 5'd0) ? mdb_pkg::ST_SUM : mdb_pkg::ST_EMIT;
				end
			end
			mdb_pkg::ST_EMIT: begin
				if (out_fire && idx_q == n_q - 5'd1) st_d = mdb_pkg::ST_SUM;
			end
			mdb_pkg::ST_SUM: begin
				if (out_fire) st_d = mdb_pkg::ST_IDLE;
			end
			default: st_d = mdb_pkg::ST_IDLE;
		endcase
	end

	assign out_valid = st_q == mdb_pkg::ST_EMIT || st_q == mdb_pkg::ST_SUM;
	always_comb begin
		if (st_q == mdb_pkg::ST_SUM) begin
			out_data.tx_word = {1'b1, rsum_q};
			out_data.last    = 1'b1;
		end else begin
			out_data.tx_word = {1'b0, word};
			out_data.last    = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= mdb_pkg::ST_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	// frame data store: no reset needed
	always_ff @(posedge clk) begin
		if (in_fire && !in_data.op && left_q > 3'd1) begin
			fdata_q[2'(dw + 3'd1 - left_q)] <= lo;
		end
		if (rd_pend_q) begin
			pollw_q[n_q[3:0]] <= ring_rdata;
		end
		if (st_q == mdb_pkg::ST_DRAIN && pend_q == '0 && jr_q) begin
			pollw_q[0] <= mdb_pkg::ST_JUST_RESET;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= 5'd6; cap_q <= 15'd500; cur_q <= 16'hFFFF;
			scale_q <= 16'd100; dec_q <= 8'd2; version_q <= 16'd1;
			cmd_q <= '0; left_q <= '0; fsum_q <= '0;
			vmode_q <= mdb_pkg::VMODE_INACTIVE; jr_q <= 1'b0;
			bill_mask_q <= '0; esc_mask_q <= '0; stacked_q <= '0;
			pend_q <= '0; head_q <= '0; tail_q <= '0;
			idx_q <= '0; n_q <= '0; rsum_q <= '0; rd_pend_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					mdb_pkg::REG_ADDR:     addr_q <= cfg_data[4:0];
					mdb_pkg::REG_CAPACITY: cap_q <= cfg_data[14:0];
					mdb_pkg::REG_CURRENCY: cur_q <= cfg_data;
					mdb_pkg::REG_SCALE:    scale_q <= cfg_data;
					mdb_pkg::REG_DECIMALS: dec_q <= cfg_data[7:0];
					mdb_pkg::REG_VERSION:  version_q <= cfg_data;
					default: ;
				endcase
			end
			case (st_q)
				mdb_pkg::ST_IDLE: begin
					idx_q <= '0;
					rsum_q <= '0;
					if (in_fire && in_data.op) begin
						if (pend_q < PEND_MAX) pend_q <= pend_q + 1'b1;
					end else if (in_fire) begin
						if (left_q == 3'd0) begin
							if (hdr_ok) begin
								cmd_q <= in_data.rx_word[2:0];
								fsum_q <= lo;
								left_q <= mdb_pkg::data_words(in_data.rx_word[2:0]) + 3'd1;
							end
						end else if (left_q > 3'd1) begin
							fsum_q <= fsum_q + lo;
							left_q <= exp_nak ? 3'd0 : left_q - 3'd1;
						end else begin
							left_q <= 3'd0;
							if (sum_ok) begin
								case (cmd_q)
									mdb_pkg::CMD_RESET: begin
										jr_q <= 1'b1;
										vmode_q <= mdb_pkg::VMODE_INACTIVE;
										bill_mask_q <= '0;
										esc_mask_q <= '0;
									end
									mdb_pkg::CMD_SETUP: begin
										vmode_q <= mdb_pkg::VMODE_DISABLED;
										n_q <= 5'd27;
									end
									mdb_pkg::CMD_BILLTYPE: begin
										bill_mask_q <= {fdata_q[0], fdata_q[1]};
										esc_mask_q <= {fdata_q[2], fdata_q[3]};
										vmode_q <= ({fdata_q[0], fdata_q[1]} != 16'd0) ?
											mdb_pkg::VMODE_ENABLED : mdb_pkg::VMODE_DISABLED;
									end
									mdb_pkg::CMD_STACKER: n_q <= 5'd2;
									mdb_pkg::CMD_EXPAND:  n_q <= 5'd29;
									default: ;
								endcase
							end
						end
					end
				end
				mdb_pkg::ST_DRAIN: begin
					// take one pending bill per cycle; stack it only when enabled
					if (pend_q != '0) begin
						pend_q <= pend_q - 1'b1;
						if (enabled) begin
							if (stacked_q < cap_q) stacked_q <= stacked_q + 1'b1;
							if (head_nx != tail_q) head_q <= head_nx;
						end
					end else if (jr_q) begin
						jr_q <= 1'b0;
						vmode_q <= mdb_pkg::VMODE_DISABLED;
						n_q <= 5'd1;
					end
				end
				mdb_pkg::ST_RING: begin
					// one event read at a time through the registered port
					if (rd_pend_q) begin
						rd_pend_q <= 1'b0;
						n_q <= n_q + 5'd1;
					end else if (head_q != tail_q && n_q != 5'd16) begin
						rd_pend_q <= 1'b1;
						tail_q <= inc(tail_q);
					end
				end
				mdb_pkg::ST_EMIT: begin
					if (out_fire) begin
						rsum_q <= rsum_q + word;
						idx_q <= idx_q + 5'd1;
					end
				end
				mdb_pkg::ST_SUM: begin
					// clear the reply length once the checksum leaves
					if (out_fire) n_q <= '0;
				end
				default: ;
			endcase
		end
	end

	// the read of the ring happens with the old tail; tail advances same edge
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input accepted while reply pending");
	assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == mdb_pkg::ST_SUM && out_fire) |=> st_q == mdb_pkg::ST_IDLE)
		else $error("sequencer did not return after checksum");
	assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= 5'd29)
		else $error("reply length out of range");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> $stable(out_data))
		else $error("stalled reply word changed");
endmodule
`default_nettype wire
